FILE: hw/rtl/asc_pkg.sv
// ============================================================================
// asc_pkg: shared types and constants of the ascending sorter
// Holds the store depth, the data word type, the phase enum and the
// control struct that the sorter drives into every cell of its chain.
// ============================================================================
package asc_pkg;

   localparam int DEPTH  = 16;
   localparam int DATA_W = 32;

   typedef logic signed [DATA_W-1:0] data_type;

   localparam data_type DATA_ZERO = '0;

   typedef enum logic {
      PHASE_FILL,
      PHASE_DRAIN
   } phase_type;

   // Per-cycle command to every cell: insert a broadcast word, or shift
   // the chain one place toward the output.
   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctrl_type;

endpackage

FILE: hw/rtl/asc_cell.sv
// ============================================================================
// asc_cell: one storage cell of the insertion chain
// Holds one word and its valid bit. On insert it keeps its word, takes the
// new word or takes its left neighbor's word; on shift it takes its right
// neighbor's word.
// ============================================================================
module asc_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  asc_pkg::cell_ctrl_type ctrl,
   input  asc_pkg::data_type     new_value,
   input  asc_pkg::data_type     prev_value,
   input  logic                  prev_valid,
   input  logic                  prev_gt,
   input  asc_pkg::data_type     next_value,
   input  logic                  next_valid,
   output asc_pkg::data_type     value,
   output logic                  valid,
   output logic                  gt
);

   asc_pkg::data_type value_ff, value_in;
   logic              valid_ff, valid_in;

   // An empty cell counts as greater than any word, so the first empty
   // cell receives the word when no stored word is greater.
   assign gt = !valid_ff || (value_ff > new_value);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.shift) begin
         value_in = next_value;
         valid_in = next_valid;
      end else if (ctrl.insert) begin
         if (gt) begin
            value_in = prev_gt ? prev_value : new_value;
            valid_in = valid_ff || prev_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

FILE: hw/rtl/ascending_sorter.sv
// ============================================================================
// ascending_sorter: streaming insertion sorter over a chain of cells
// Collects a set of signed words, keeps it in ascending order as it
// arrives, and emits the sorted set when the word marked last is taken.
// ============================================================================
// Latency: a word is inserted in the cycle it is accepted; the first sorted
// word is offered in the cycle after the last word of a set is accepted.
// Throughput: one input word per cycle while filling, then one result word
// per cycle while draining and rsp_ready is high; the words of a new set are
// accepted only after the final result of the previous set is taken.
// Reset: synchronous; clears every valid bit and returns to the fill phase.
module ascending_sorter (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [31:0]       req_value,
   input  logic                     req_is_last,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [31:0]       rsp_sorted_value,
   output logic                     rsp_is_final
);

   localparam int D = asc_pkg::DEPTH;

   asc_pkg::phase_type     phase_ff, phase_in;
   asc_pkg::cell_ctrl_type ctrl;

   asc_pkg::data_type cell_value [D];
   logic [D-1:0]      cell_valid;
   logic [D-1:0]      cell_gt;

   logic req_fire;
   logic rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // A word arriving while every cell is occupied is dropped, but its last
   // flag still starts the drain.
   assign ctrl.insert = req_fire && !cell_valid[D-1];
   assign ctrl.shift  = rsp_fire;

   // The chain: cell 0 is the head and holds the smallest word. During
   // insertion every cell compares against the broadcast word and the
   // greater words move one place right; during the drain the words move
   // one place left and leave through cell 0.
   for (genvar i = 0; i < D; i++) begin : g_cell
      asc_pkg::data_type prev_value, next_value;
      logic              prev_valid, prev_gt, next_valid;

      if (i == 0) begin : g_head
         assign prev_value = asc_pkg::DATA_ZERO;
         assign prev_valid = 1'b1;
         assign prev_gt    = 1'b0;
      end else begin : g_body
         assign prev_value = cell_value[i-1];
         assign prev_valid = cell_valid[i-1];
         assign prev_gt    = cell_gt[i-1];
      end

      if (i == D - 1) begin : g_tail
         assign next_value = asc_pkg::DATA_ZERO;
         assign next_valid = 1'b0;
      end else begin : g_link
         assign next_value = cell_value[i+1];
         assign next_valid = cell_valid[i+1];
      end

      asc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_value  (req_value),
         .prev_value (prev_value),
         .prev_valid (prev_valid),
         .prev_gt    (prev_gt),
         .next_value (next_value),
         .next_valid (next_valid),
         .value      (cell_value[i]),
         .valid      (cell_valid[i]),
         .gt         (cell_gt[i])
      );
   end

   // Phase register: fill until the last word, then drain until the final
   // result is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= asc_pkg::PHASE_FILL;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // Ready is always high while filling and the final flag already implies
   // a valid head cell, so the handshakes are written out from the ports.
   always_comb begin
      phase_in  = phase_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (phase_ff)
         asc_pkg::PHASE_FILL: begin
            req_ready = 1'b1;
            if (req_valid && req_is_last) begin
               phase_in = asc_pkg::PHASE_DRAIN;
            end
         end
         asc_pkg::PHASE_DRAIN: begin
            rsp_valid = cell_valid[0];
            if (rsp_ready && rsp_is_final) begin
               phase_in = asc_pkg::PHASE_FILL;
            end
         end
         default: begin
            phase_in = asc_pkg::PHASE_FILL;
         end
      endcase
   end

   // The head cell is the output register; the result is final when the
   // cell behind it is empty.
   assign rsp_sorted_value = cell_value[0];
   assign rsp_is_final     = cell_valid[0] && !cell_valid[1];

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // The two sides never run together: the block drains or fills.
   a_phase_excl : assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input accepted while results are pending");

   // The last word of a set always leaves something to drain.
   a_drain_start : assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_is_last) |=> rsp_valid)
      else $error("no result after the last word of a set");

   // Consecutive results of one set come out in ascending order.
   a_ascending : assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && !rsp_is_final) |=>
         (rsp_valid && ($past(rsp_sorted_value) <= rsp_sorted_value)))
      else $error("results out of order");

   // Taking the final result empties the chain.
   a_drain_end : assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_is_final) |=> (cell_valid == '0))
      else $error("chain not empty after the final result");

endmodule
